>>> hw/rtl/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define AST_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/pjm_pkg.sv
`timescale 1ns / 1ps

package pjm_pkg;

    // timestamp width used for the interval, at most the 63 bits of the field
    localparam int TIME_WIDTH = 64;
    localparam int TS_FIELD_W = 63;
    localparam int TS_USED_W  = (TIME_WIDTH < TS_FIELD_W) ? TIME_WIDTH : TS_FIELD_W;
    localparam int DIFF_W     = TS_USED_W + 1;
    localparam int LAT_W      = DIFF_W + 1;

    localparam logic signed [31:0] SAT_POS_LIMIT = 32'sh7fff_ffff;
    localparam logic signed [31:0] SAT_NEG_LIMIT = 32'sh8000_0000;
    localparam logic [30:0]        JITTER_MAX    = 31'h7fff_ffff;
    localparam logic [31:0]        NOMINAL_RST   = 32'd1000000;

    typedef struct packed {
        logic [TS_FIELD_W-1:0] timestamp_ns;
        logic                  reset_level;
        logic                  clear_request;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] interval_ns;
        logic signed [31:0] latency_ns;
        logic signed [31:0] min_latency_ns;
        logic signed [31:0] max_latency_ns;
        logic [30:0]        worst_jitter_ns;
        logic [31:0]        sample_total;
        logic               sample_emitted;
        logic               stats_cleared;
    } t_out_item;

    // saturate a wide signed value to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [LAT_W-1:0] v);
        logic [LAT_W-32:0] hi_bits;
        hi_bits = v[LAT_W-1:31];
        if ((hi_bits == '0) || (hi_bits == '1)) begin
            return v[31:0];
        end else if (v[LAT_W-1]) begin
            return SAT_NEG_LIMIT;
        end else begin
            return SAT_POS_LIMIT;
        end
    endfunction

endpackage

>>> hw/rtl/period_jitter_monitor_top.sv
`timescale 1ns / 1ps
// period jitter monitor
// input channel (i_in_valid / o_in_ready / i_in_data): one transaction per
//   activation, carrying a timestamp in ns, the reset line level and a
//   software clear request
// output channel (o_out_valid / i_out_ready / o_out_data): exactly one
//   transaction per input transaction, in order, with the held interval,
//   latency, min / max latency, worst jitter, sample count and two flags
// config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): writes the nominal
//   period; o_cfg_ready is always high, write only while the block is idle
// flow: an input transaction lands in the input register and moves on to
//   the result register once that is free or drains
// throughput: one transaction per cycle while the output is not stalled; the
//   interval subtract, the latency subtract and the min / max compares all
//   sit between the two registers
// reset (i_rst_n low, synchronous): both registers empty, statistics and
//   baseline zeroed, nominal period back to 1000000 ns
// stall: with the result register full and i_out_ready low, the input
//   register still takes one more transaction, then o_in_ready drops
module period_jitter_monitor_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pjm_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pjm_pkg::t_out_item o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [31:0]       i_cfg_data
);
    import pjm_pkg::*;

    // config register
    logic [31:0] r_nominal;

    // input register
    logic     r_in_valid;
    t_in_item r_in;

    // result register
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    // statistics state
    logic [TS_USED_W-1:0] r_last_time, n_last_time;
    logic                 r_have_base, n_have_base;
    logic signed [31:0]   r_held_iv, n_held_iv;
    logic signed [31:0]   r_held_lat, n_held_lat;
    logic signed [31:0]   r_min_lat, n_min_lat;
    logic signed [31:0]   r_max_lat, n_max_lat;
    logic [30:0]          r_worst, n_worst;
    logic [31:0]          r_count, n_count;
    logic                 r_line_prev, n_line_prev;

    // datapath
    logic                     adv;
    logic [TS_USED_W-1:0]     now;
    logic signed [DIFF_W-1:0] diff;
    logic signed [LAT_W-1:0]  diff_ext;
    logic signed [LAT_W-1:0]  lat_full;
    logic signed [31:0]       iv_sat;
    logic signed [31:0]       lat_sat;
    logic signed [31:0]       lat_neg;
    logic [30:0]              abs_lat;
    logic                     line_edge;
    logic                     do_clear;
    logic                     do_sample;

    // the input register moves on when the result register is free or drains
    assign adv         = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || adv;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        now      = r_in.timestamp_ns[TS_USED_W-1:0];
        // both timestamps are non-negative, so one extra bit holds the difference
        diff     = {1'b0, now} - {1'b0, r_last_time};
        diff_ext = {diff[DIFF_W-1], diff};
        lat_full = diff_ext - {{(LAT_W-32){1'b0}}, r_nominal};
        iv_sat   = sat32(diff_ext);
        lat_sat  = sat32(lat_full);
        lat_neg  = -lat_sat;
        // a saturated latency also saturates its magnitude
        if (lat_sat == SAT_NEG_LIMIT) begin
            abs_lat = JITTER_MAX;
        end else if (lat_sat[31]) begin
            abs_lat = lat_neg[30:0];
        end else begin
            abs_lat = lat_sat[30:0];
        end

        line_edge = r_in.reset_level && !r_line_prev;
        do_clear  = r_in.clear_request || line_edge;
        do_sample = !do_clear && r_have_base;

        n_last_time = r_last_time;
        n_have_base = r_have_base;
        n_held_iv   = r_held_iv;
        n_held_lat  = r_held_lat;
        n_min_lat   = r_min_lat;
        n_max_lat   = r_max_lat;
        n_worst     = r_worst;
        n_count     = r_count;
        n_line_prev = r_line_prev;

        if (adv) begin
            n_line_prev = r_in.reset_level;
            n_last_time = now;
            n_have_base = 1'b1;
            if (do_clear) begin
                n_held_iv  = '0;
                n_held_lat = '0;
                n_min_lat  = '0;
                n_max_lat  = '0;
                n_worst    = '0;
                n_count    = '0;
            end else if (r_have_base) begin
                // first sample after a clear seeds min and max
                if ((r_count == '0) || (lat_sat < r_min_lat)) begin
                    n_min_lat = lat_sat;
                end
                if ((r_count == '0) || (lat_sat > r_max_lat)) begin
                    n_max_lat = lat_sat;
                end
                if (abs_lat > r_worst) begin
                    n_worst = abs_lat;
                end
                n_count    = r_count + 32'd1;
                n_held_iv  = iv_sat;
                n_held_lat = lat_sat;
            end
        end

        n_out.interval_ns     = n_held_iv;
        n_out.latency_ns      = n_held_lat;
        n_out.min_latency_ns  = n_min_lat;
        n_out.max_latency_ns  = n_max_lat;
        n_out.worst_jitter_ns = n_worst;
        n_out.sample_total    = n_count;
        n_out.sample_emitted  = do_sample;
        n_out.stats_cleared   = do_clear;
    end

    // config write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nominal <= NOMINAL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_nominal <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    // statistics state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
            r_have_base <= 1'b0;
            r_held_iv   <= '0;
            r_held_lat  <= '0;
            r_min_lat   <= '0;
            r_max_lat   <= '0;
            r_worst     <= '0;
            r_count     <= '0;
            r_line_prev <= 1'b0;
        end else begin
            r_last_time <= n_last_time;
            r_have_base <= n_have_base;
            r_held_iv   <= n_held_iv;
            r_held_lat  <= n_held_lat;
            r_min_lat   <= n_min_lat;
            r_max_lat   <= n_max_lat;
            r_worst     <= n_worst;
            r_count     <= n_count;
            r_line_prev <= n_line_prev;
        end
    end

endmodule

>>> hw/rtl/pjm_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pjm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input pjm_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input pjm_pkg::t_out_item o_out_data
);
    import pjm_pkg::*;

    logic in_stall;
    logic out_stall;
    logic flags_ok;
    logic clear_zero;
    logic sample_in_range;

    assign in_stall   = i_in_valid && !o_in_ready;
    assign out_stall  = o_out_valid && !i_out_ready;
    assign flags_ok   = !(o_out_data.sample_emitted && o_out_data.stats_cleared);
    assign clear_zero = (o_out_data.sample_total == 32'd0)
                     && (o_out_data.worst_jitter_ns == 31'd0)
                     && (o_out_data.min_latency_ns == 32'sd0)
                     && (o_out_data.max_latency_ns == 32'sd0);
    assign sample_in_range = (o_out_data.min_latency_ns <= o_out_data.latency_ns)
                          && (o_out_data.latency_ns <= o_out_data.max_latency_ns);

    // stalled input transaction holds
    `AST_NEXT(a_in_hold, i_clk, i_rst_n, in_stall, i_in_valid && $stable(i_in_data))

    // stalled result transaction holds
    `AST_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_out_data))

    // a transaction never both clears and samples
    `AST_NOW(a_flags_excl, i_clk, i_rst_n, o_out_valid, flags_ok)

    // a clearing transaction shows zeroed statistics
    `AST_NOW(a_clear_zero, i_clk, i_rst_n, o_out_valid && o_out_data.stats_cleared, clear_zero)

    // a fresh sample lies between the running min and max
    `AST_NOW(a_sample_range, i_clk, i_rst_n, o_out_valid && o_out_data.sample_emitted, sample_in_range)

endmodule

bind period_jitter_monitor_top pjm_checker u_pjm_checker (.*);

>>> tb/period_jitter_monitor_top_tb.sv
`timescale 1ns / 1ps

module period_jitter_monitor_top_tb;
    import pjm_pkg::*;

    // tracks the jitter statistics the block should hold and the reports still owed
    class jitter_stats_tracker;
        logic [31:0]        nom_period;
        logic [63:0]        last_ts;
        bit                 have_base;
        bit                 line_prev;
        logic signed [31:0] held_interval;
        logic signed [31:0] held_latency;
        logic signed [31:0] min_lat;
        logic signed [31:0] max_lat;
        logic [30:0]        worst;
        logic [31:0]        samples;
        t_out_item          expected_reports[$];
        int                 fail_count;
        int                 activations;
        int                 reports;
        int                 sample_hits;
        int                 clears;

        function new();
            nom_period    = NOMINAL_RST;
            last_ts       = '0;
            have_base     = 1'b0;
            line_prev     = 1'b0;
            held_interval = '0;
            held_latency  = '0;
            min_lat       = '0;
            max_lat       = '0;
            worst         = '0;
            samples       = '0;
            fail_count    = 0;
            activations   = 0;
            reports       = 0;
            sample_hits   = 0;
            clears        = 0;
        endfunction

        function void set_period(logic [31:0] v);
            nom_period = v;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        static function logic signed [31:0] clamp_to_i32(logic signed [79:0] v);
            if (v > 80'sd2147483647) return SAT_POS_LIMIT;
            if (v < -80'sd2147483648) return SAT_NEG_LIMIT;
            return v[31:0];
        endfunction

        // one accepted activation: update the statistics and queue the report
        function void note_activation(t_in_item it);
            logic [63:0]        now;
            logic signed [79:0] span;
            logic signed [79:0] lat_w;
            logic signed [79:0] mag;
            logic signed [31:0] lat;
            logic [30:0]        abs_lat;
            bit                 rise;
            t_out_item          rep;
            now = '0;
            now[TS_USED_W-1:0] = it.timestamp_ns[TS_USED_W-1:0];
            rise = it.reset_level && !line_prev;
            line_prev = it.reset_level;
            rep = '0;
            if (it.clear_request || rise) begin
                // clear request and reset edge together still clear once
                held_interval = '0;
                held_latency  = '0;
                min_lat       = '0;
                max_lat       = '0;
                worst         = '0;
                samples       = '0;
                rep.stats_cleared = 1'b1;
                clears++;
            end else if (have_base) begin
                span    = $signed({16'b0, now}) - $signed({16'b0, last_ts});
                lat_w   = span - $signed({48'b0, nom_period});
                lat     = clamp_to_i32(lat_w);
                mag     = (lat_w < 0) ? -lat_w : lat_w;
                abs_lat = (mag > 80'sd2147483647) ? JITTER_MAX : mag[30:0];
                // first sample after a clear seeds min and max
                if (samples == 0 || lat < min_lat) min_lat = lat;
                if (samples == 0 || lat > max_lat) max_lat = lat;
                if (abs_lat > worst) worst = abs_lat;
                samples++;
                held_interval = clamp_to_i32(span);
                held_latency  = lat;
                rep.sample_emitted = 1'b1;
                sample_hits++;
            end
            last_ts   = now;
            have_base = 1'b1;
            rep.interval_ns     = held_interval;
            rep.latency_ns      = held_latency;
            rep.min_latency_ns  = min_lat;
            rep.max_latency_ns  = max_lat;
            rep.worst_jitter_ns = worst;
            rep.sample_total    = samples;
            expected_reports.push_back(rep);
            activations++;
        endfunction

        function void flag(string msg);
            fail_count++;
            if (fail_count <= 100) $error("%s", msg);
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                flag($sformatf("%s: expected %0d, actual %0d", name, want, got));
            end
        endfunction

        function void check_report(t_out_item got);
            t_out_item want;
            reports++;
            if (expected_reports.size() == 0) begin
                flag("report transaction with no activation outstanding");
                return;
            end
            want = expected_reports.pop_front();
            compare_field("interval_ns", $signed(want.interval_ns), $signed(got.interval_ns));
            compare_field("latency_ns", $signed(want.latency_ns), $signed(got.latency_ns));
            compare_field("min_latency_ns", $signed(want.min_latency_ns),
                          $signed(got.min_latency_ns));
            compare_field("max_latency_ns", $signed(want.max_latency_ns),
                          $signed(got.max_latency_ns));
            compare_field("worst_jitter_ns", want.worst_jitter_ns, got.worst_jitter_ns);
            compare_field("sample_total", want.sample_total, got.sample_total);
            compare_field("sample_emitted", want.sample_emitted, got.sample_emitted);
            compare_field("stats_cleared", want.stats_cleared, got.stats_cleared);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        act_valid;
    logic        act_ready;
    t_in_item    act_data;
    logic        rep_valid;
    logic        rep_ready;
    t_out_item   rep_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    jitter_stats_tracker sb = new();

    bit          sender_gaps;
    bit          receiver_gaps;
    bit          hold_req;
    logic [31:0] cur_period;

    localparam int HOLD_CYCLES = 250;

    period_jitter_monitor_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (act_valid),
        .o_in_ready  (act_ready),
        .i_in_data   (act_data),
        .o_out_valid (rep_valid),
        .i_out_ready (rep_ready),
        .o_out_data  (rep_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("[period_jitter_monitor_top] ERROR");
        $finish;
    end

    // every handshake is sampled with the values from before the edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) sb.set_period(cfg_data);
            if (rep_valid && rep_ready) sb.check_report(rep_data);
            if (act_valid && act_ready) sb.note_activation(act_data);
        end
    end

    // report side: short random stalls, plus a long hold-off on request
    initial begin
        rep_ready = 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (hold_req) begin
                rep_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
                rep_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end else begin
                rep_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // offer one activation and hold it until the block takes it
    task automatic send_activation(input t_in_item it);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            act_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        act_valid <= 1'b1;
        act_data  <= it;
        @(posedge clk);
        while (!act_ready) @(posedge clk);
    endtask

    task automatic activate(input logic [62:0] ts, input bit line, input bit clr);
        t_in_item it;
        it.timestamp_ns  = ts;
        it.reset_level   = line;
        it.clear_request = clr;
        send_activation(it);
    endtask

    // wait until every report is back, then let the pipeline go quiet
    task automatic settle();
        act_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_period(input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cur_period = v;
    endtask

    // mostly periodic activations with random jitter, the rest clears, reset
    // line toggles, random jumps and backward steps
    task automatic run_phase(input int n_items, input bit gaps, input bit with_hold);
        t_in_item    it;
        logic [62:0] ts;
        logic [63:0] u;
        logic [63:0] spread;
        logic [63:0] step;
        bit          reset_line;
        int          r;
        int          pick;
        u = {$urandom, $urandom};
        ts = u[62:0];
        reset_line = 1'b0;
        for (int k = 0; k < n_items; k++) begin
            if (k % 64 == 0) begin
                // some stretches run with no idling at all
                sender_gaps   = gaps && ($urandom_range(0, 3) != 0);
                receiver_gaps = gaps && ($urandom_range(0, 3) != 0);
            end
            if (with_hold && k == n_items / 3) hold_req = 1'b1;
            pick = $urandom_range(0, 9);
            spread = (pick < 6) ? 64'd16 : (pick < 8) ? 64'd4096 :
                     (pick < 9) ? (64'd1 << 20) : (64'd1 << 33);
            u = {$urandom, $urandom};
            step = 64'(cur_period) + u % (2 * spread + 1) - spread;
            ts = ts + step[62:0];
            it.clear_request = 1'b0;
            r = $urandom_range(0, 99);
            if (r < 70) begin
                // plain periodic activation
            end else if (r < 76) begin
                it.clear_request = 1'b1;
            end else if (r < 84) begin
                reset_line = !reset_line;
            end else if (r < 90) begin
                u = {$urandom, $urandom};
                ts = u[62:0];
            end else if (r < 95) begin
                u = {$urandom, $urandom} >> $urandom_range(0, 62);
                ts = ts - u[62:0];
            end else begin
                reset_line = 1'b1;
                it.clear_request = 1'b1;
            end
            it.timestamp_ns = ts;
            it.reset_level  = reset_line;
            send_activation(it);
        end
    endtask

    initial begin
        logic [62:0] t;
        rst_n         = 1'b0;
        act_valid     = 1'b0;
        act_data      = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        hold_req      = 1'b0;
        cur_period    = NOMINAL_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: small period first
        write_period(32'd1000);
        activate(63'd100, 1'b0, 1'b0);              // no baseline yet
        activate(63'd1100, 1'b0, 1'b0);             // seeds min and max
        activate(63'd2300, 1'b0, 1'b0);
        activate(63'd3100, 1'b0, 1'b0);
        activate(63'd4100, 1'b0, 1'b1);             // software clear
        activate(63'd5100, 1'b0, 1'b0);
        activate(63'h4000_0000_0000_0000, 1'b0, 1'b0); // huge forward jump
        activate(63'd0, 1'b0, 1'b0);                // huge backward step
        activate(63'h100_0000_0000, 1'b0, 1'b1);
        // latency lands exactly on the most negative value
        t = 63'h100_0000_0000 - 63'd2147482648;
        activate(t, 1'b0, 1'b0);
        t = t + 63'd1000;
        activate(t, 1'b1, 1'b0);                    // reset line rising edge
        t = t + 63'd1000;
        activate(t, 1'b1, 1'b0);                    // line held high, no clear
        t = t + 63'd1000;
        activate(t, 1'b1, 1'b1);
        t = t + 63'd1200;
        activate(t, 1'b0, 1'b0);
        t = t + 63'd900;
        activate(t, 1'b1, 1'b1);                    // edge and clear together
        activate(63'h7fff_ffff_ffff_ffff, 1'b0, 1'b0);
        activate(63'h7fff_ffff_ffff_ffff, 1'b0, 1'b0);
        settle();

        // zero period: interval hits both 32-bit limits exactly
        write_period(32'd0);
        activate(63'h2_0000_0000, 1'b0, 1'b1);
        activate(63'h1_8000_0000, 1'b0, 1'b0);
        activate(63'h1_8000_0000 + 63'h7fff_ffff, 1'b0, 1'b0);
        settle();

        // largest period
        write_period(32'hffff_ffff);
        activate(63'd0, 1'b0, 1'b1);
        activate(63'hffff_ffff, 1'b0, 1'b0);
        activate(63'h1_0000_0004, 1'b0, 1'b0);
        activate(63'h1_0000_0004, 1'b0, 1'b0);
        settle();

        // random phases, one per period setting
        write_period(NOMINAL_RST);
        run_phase(225, 1'b1, 1'b1);
        settle();
        write_period($urandom);
        run_phase(225, 1'b1, 1'b0);
        settle();
        write_period($urandom_range(0, 50));
        run_phase(225, 1'b1, 1'b1);
        settle();
        write_period(32'hffff_ffff);
        run_phase(225, 1'b1, 1'b0);
        settle();
        // last stretch runs with no idling on either side
        write_period(32'd0);
        run_phase(225, 1'b0, 1'b0);

        settle();
        repeat (10) @(posedge clk);
        $display("checked %0d reports for %0d activations: %0d latency samples, %0d clears",
                 sb.reports, sb.activations, sb.sample_hits, sb.clears);
        $display("period swept over 0, 2^32-1, reset value and random settings, with %0d-cycle holds",
                 HOLD_CYCLES);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("[period_jitter_monitor_top] OK");
        end else begin
            $display("[period_jitter_monitor_top] ERROR");
        end
        $finish;
    end

endmodule
